### hdl/assert_macros.svh
// Assertion macros shared by the calendar date adder modules.
// Expects clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an expression at every clock edge outside reset.
`define CDA_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define CDA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/cda_pkg.sv
// Types, microcode encoding and calendar helpers for the calendar date adder.
// No dependencies; every module file imports this package.
package cda_pkg;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] amount;
        logic [15:0] set_year;
        logic [3:0]  set_month;
        logic [4:0]  set_day;
    } req_t;

    typedef struct packed {
        logic [15:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic        error;
    } res_t;

    localparam logic [1:0] ACT_SET    = 2'd0;
    localparam logic [1:0] ACT_DAYS   = 2'd1;
    localparam logic [1:0] ACT_MONTHS = 2'd2;
    localparam logic [1:0] ACT_YEARS  = 2'd3;

    typedef logic [3:0] op_t;
    localparam op_t OP_NOP       = 4'd0;
    localparam op_t OP_LOAD      = 4'd1;
    localparam op_t OP_LEAP      = 4'd2;
    localparam op_t OP_SET_CHECK = 4'd3;
    localparam op_t OP_WALK      = 4'd4;
    localparam op_t OP_DIV_INIT  = 4'd5;
    localparam op_t OP_DIV_STEP  = 4'd6;
    localparam op_t OP_MON_APPLY = 4'd7;
    localparam op_t OP_YEAR_ADD  = 4'd8;
    localparam op_t OP_FIX_DAY   = 4'd9;
    localparam op_t OP_EMIT      = 4'd10;

    typedef logic [1:0] seq_t;
    localparam seq_t SEQ_NEXT     = 2'd0;
    localparam seq_t SEQ_JUMP     = 2'd1;
    localparam seq_t SEQ_BRANCH   = 2'd2;
    localparam seq_t SEQ_DISPATCH = 2'd3;

    typedef logic [1:0] cond_t;
    localparam cond_t COND_NONE   = 2'd0;
    localparam cond_t COND_OVF    = 2'd1;
    localparam cond_t COND_FITS   = 2'd2;

    typedef logic [3:0] pc_t;
    localparam pc_t PC_IDLE     = 4'd0;
    localparam pc_t PC_SET      = 4'd1;
    localparam pc_t PC_SET_CHK  = 4'd2;
    localparam pc_t PC_DAYS     = 4'd3;
    localparam pc_t PC_WALK     = 4'd4;
    localparam pc_t PC_WALK_LP  = 4'd5;
    localparam pc_t PC_MONTHS   = 4'd6;
    localparam pc_t PC_DIV      = 4'd7;
    localparam pc_t PC_MON_APP  = 4'd8;
    localparam pc_t PC_FIX      = 4'd9;
    localparam pc_t PC_FIX_DAY  = 4'd10;
    localparam pc_t PC_YEARS    = 4'd11;
    localparam pc_t PC_EMIT     = 4'd12;

    typedef struct packed {
        op_t   op;
        seq_t  seq;
        cond_t cond;
        pc_t   target;
    } uword_t;

    typedef struct packed {
        logic ovf;
        logic fits;
        logic out_busy;
    } status_t;

    localparam logic [15:0] RESET_YEAR  = 16'd2001;
    localparam logic [3:0]  RESET_MONTH = 4'd1;
    localparam logic [4:0]  RESET_DAY   = 5'd1;
    localparam logic [3:0]  MONTHS      = 4'd12;

    // Reciprocal of 3 scaled by 2^17, exact for dividends below 2^16.
    localparam logic [15:0] INV3        = 16'd43691;

    // Multiplicative inverse of 25 modulo 2^16 and the largest multiple quotient.
    localparam logic [15:0] INV25       = 16'd23593;
    localparam logic [15:0] DIV25_LIMIT = 16'd2621;

    function automatic logic is_leap(input logic [15:0] y);
        logic [31:0] prod;
        logic        div25;
        prod  = 32'(y) * 32'(INV25);
        div25 = (prod[15:0] <= DIV25_LIMIT);
        return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

### hdl/cda_ucode_rom.sv
// Control store of the calendar date adder: one control word per step.
// Depends on cda_pkg.
module cda_ucode_rom (
    input  cda_pkg::pc_t    pc,
    output cda_pkg::uword_t uword
);
    import cda_pkg::*;

    always_comb
    begin
        case (pc)
            PC_IDLE:    uword = '{OP_LOAD,      SEQ_DISPATCH, COND_NONE,   PC_IDLE};
            PC_SET:     uword = '{OP_LEAP,      SEQ_NEXT,     COND_NONE,   PC_IDLE};
            PC_SET_CHK: uword = '{OP_SET_CHECK, SEQ_JUMP,     COND_NONE,   PC_EMIT};
            PC_DAYS:    uword = '{OP_LEAP,      SEQ_BRANCH,   COND_OVF,    PC_EMIT};
            PC_WALK:    uword = '{OP_WALK,      SEQ_BRANCH,   COND_FITS,   PC_EMIT};
            PC_WALK_LP: uword = '{OP_NOP,       SEQ_JUMP,     COND_NONE,   PC_DAYS};
            PC_MONTHS:  uword = '{OP_DIV_INIT,  SEQ_NEXT,     COND_NONE,   PC_IDLE};
            PC_DIV:     uword = '{OP_DIV_STEP,  SEQ_NEXT,     COND_NONE,   PC_IDLE};
            PC_MON_APP: uword = '{OP_MON_APPLY, SEQ_NEXT,     COND_NONE,   PC_IDLE};
            PC_FIX:     uword = '{OP_LEAP,      SEQ_BRANCH,   COND_OVF,    PC_EMIT};
            PC_FIX_DAY: uword = '{OP_FIX_DAY,   SEQ_JUMP,     COND_NONE,   PC_EMIT};
            PC_YEARS:   uword = '{OP_YEAR_ADD,  SEQ_JUMP,     COND_NONE,   PC_FIX};
            PC_EMIT:    uword = '{OP_EMIT,      SEQ_JUMP,     COND_NONE,   PC_IDLE};
            default:    uword = '{OP_NOP,       SEQ_JUMP,     COND_NONE,   PC_IDLE};
        endcase
    end

endmodule

### hdl/cda_sequencer.sv
// Step counter of the calendar date adder: holds, advances, jumps, branches and dispatches.
// Depends on cda_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cda_sequencer (
    input  logic             clk,
    input  logic             rst_n,
    input  cda_pkg::uword_t  uword,
    input  cda_pkg::status_t status,
    input  logic             req_valid,
    input  logic [1:0]       action,
    output cda_pkg::pc_t     pc,
    output logic             run
);
    import cda_pkg::*;

    pc_t  pc_reg;
    pc_t  pc_next;
    logic cond_true;
    pc_t  entry;

    always_comb
    begin
        case (uword.cond)
            COND_OVF:    cond_true = status.ovf;
            COND_FITS:   cond_true = status.fits;
            default:     cond_true = 1'b0;
        endcase
    end

    always_comb
    begin
        case (action)
            ACT_SET:    entry = PC_SET;
            ACT_DAYS:   entry = PC_DAYS;
            ACT_MONTHS: entry = PC_MONTHS;
            default:    entry = PC_YEARS;
        endcase
    end

    assign run = !((uword.op == OP_LOAD && !req_valid) ||
                   (uword.op == OP_EMIT && status.out_busy));

    always_comb
    begin
        pc_next = pc_reg;
        if (run)
        begin
            case (uword.seq)
                SEQ_NEXT:     pc_next = pc_reg + 4'd1;
                SEQ_JUMP:     pc_next = uword.target;
                SEQ_BRANCH:   pc_next = cond_true ? uword.target : pc_reg + 4'd1;
                SEQ_DISPATCH: pc_next = entry;
                default:      pc_next = PC_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assign pc = pc_reg;

    `CDA_ASSERT_NEXT(a_emit_to_idle, run && uword.op == OP_EMIT, pc_reg == PC_IDLE, "emit did not return to idle")

endmodule

### hdl/cda_datapath.sv
// Date registers, working registers and result register of the calendar date adder.
// Depends on cda_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cda_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  cda_pkg::uword_t   uword,
    input  logic              run,
    input  cda_pkg::req_t     req,
    input  logic              res_stall,
    output logic              res_valid,
    output cda_pkg::res_t     res,
    output cda_pkg::status_t  status
);
    import cda_pkg::*;

    logic [15:0] cur_year_reg, cur_year_next;
    logic [3:0]  cur_month_reg, cur_month_next;
    logic [4:0]  cur_day_reg, cur_day_next;
    logic [16:0] wy_reg, wy_next;
    logic [3:0]  wm_reg, wm_next;
    logic [4:0]  wd_reg, wd_next;
    logic [15:0] n_reg, n_next;
    logic        err_reg, err_next;
    logic        leap_reg, leap_next;
    logic [16:0] dq_reg, dq_next;
    logic [3:0]  rem_reg, rem_next;
    logic        res_valid_reg, res_valid_next;
    res_t        res_reg, res_next;

    logic [4:0]  md;
    logic [16:0] sum_dn;
    logic        fits;
    logic [3:0]  m_adv;
    logic [16:0] y_adv;
    logic [31:0] div_prod;
    logic [12:0] div_q;
    logic        set_bad;
    logic        commit_ok;

    always_comb
    begin
        md        = month_days(wm_reg, leap_reg);
        sum_dn    = {1'b0, n_reg} + 17'(wd_reg);
        fits      = (sum_dn <= 17'(md));
        m_adv     = (wm_reg >= MONTHS) ? 4'd1 : wm_reg + 4'd1;
        y_adv     = (wm_reg >= MONTHS) ? wy_reg + 17'd1 : wy_reg;
        div_prod  = 32'(dq_reg[16:2]) * 32'(INV3);
        div_q     = div_prod[29:17];
        set_bad   = (wm_reg == 4'd0) || (wm_reg > MONTHS) || (wd_reg == 5'd0) || (wd_reg > md);
        commit_ok = !err_reg && !wy_reg[16];
    end

    always_comb
    begin
        cur_year_next  = cur_year_reg;
        cur_month_next = cur_month_reg;
        cur_day_next   = cur_day_reg;
        wy_next        = wy_reg;
        wm_next        = wm_reg;
        wd_next        = wd_reg;
        n_next         = n_reg;
        err_next       = err_reg;
        leap_next      = leap_reg;
        dq_next        = dq_reg;
        rem_next       = rem_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && res_stall;
        if (run)
        begin
            case (uword.op)
                OP_LOAD:
                begin
                    n_next   = req.amount;
                    err_next = 1'b0;
                    if (req.action == ACT_SET)
                    begin
                        wy_next = {1'b0, req.set_year};
                        wm_next = req.set_month;
                        wd_next = req.set_day;
                    end
                    else
                    begin
                        wy_next = {1'b0, cur_year_reg};
                        wm_next = cur_month_reg;
                        wd_next = cur_day_reg;
                    end
                end
                OP_LEAP:
                begin
                    leap_next = is_leap(wy_reg[15:0]);
                end
                OP_SET_CHECK:
                begin
                    err_next = set_bad;
                end
                OP_WALK:
                begin
                    if (fits)
                    begin
                        wd_next = sum_dn[4:0];
                    end
                    else
                    begin
                        n_next  = n_reg - (16'(md) - 16'(wd_reg));
                        wd_next = 5'd0;
                        wm_next = m_adv;
                        wy_next = y_adv;
                    end
                end
                OP_DIV_INIT:
                begin
                    dq_next = 17'(wm_reg) + 17'(n_reg) - 17'd1;
                end
                OP_DIV_STEP:
                begin
                    rem_next = dq_reg[3:0] - ({div_q[1:0], 2'b00} + {div_q[0], 3'b000});
                    dq_next  = 17'(div_q);
                end
                OP_MON_APPLY:
                begin
                    wm_next = rem_reg + 4'd1;
                    wy_next = wy_reg + dq_reg;
                end
                OP_YEAR_ADD:
                begin
                    wy_next = wy_reg + {1'b0, n_reg};
                end
                OP_FIX_DAY:
                begin
                    if (wd_reg > md)
                    begin
                        wd_next = 5'd1;
                        wm_next = m_adv;
                        wy_next = y_adv;
                    end
                end
                OP_EMIT:
                begin
                    res_valid_next = 1'b1;
                    res_next.error = !commit_ok;
                    if (commit_ok)
                    begin
                        cur_year_next  = wy_reg[15:0];
                        cur_month_next = wm_reg;
                        cur_day_next   = wd_reg;
                        res_next.year  = wy_reg[15:0];
                        res_next.month = wm_reg;
                        res_next.day   = wd_reg;
                    end
                    else
                    begin
                        res_next.year  = cur_year_reg;
                        res_next.month = cur_month_reg;
                        res_next.day   = cur_day_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_year_reg  <= RESET_YEAR;
            cur_month_reg <= RESET_MONTH;
            cur_day_reg   <= RESET_DAY;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            cur_year_reg  <= cur_year_next;
            cur_month_reg <= cur_month_next;
            cur_day_reg   <= cur_day_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wy_reg   <= wy_next;
        wm_reg   <= wm_next;
        wd_reg   <= wd_next;
        n_reg    <= n_next;
        err_reg  <= err_next;
        leap_reg <= leap_next;
        dq_reg   <= dq_next;
        rem_reg  <= rem_next;
        res_reg  <= res_next;
    end

    assign res_valid       = res_valid_reg;
    assign res             = res_reg;
    assign status.ovf      = wy_reg[16];
    assign status.fits     = fits;
    assign status.out_busy = res_valid_reg && res_stall;

    `CDA_ASSERT(a_month_range, cur_month_reg >= 4'd1 && cur_month_reg <= MONTHS, "stored month out of range")
    `CDA_ASSERT(a_day_range, cur_day_reg != 5'd0 && cur_day_reg <= month_days(cur_month_reg, is_leap(cur_year_reg)), "stored day out of range")

endmodule

### hdl/calendar_date_adder.sv
// Top level of the calendar date adder: control store, sequencer and datapath.
// Depends on cda_pkg, cda_ucode_rom, cda_sequencer and cda_datapath.
//
//   channel   direction   handshake               payload
//   request   in          req_valid / req_stall   req_data (cda_pkg::req_t)
//   result    out         res_valid / res_stall   res_data (cda_pkg::res_t)
//
// Each request runs a microcode program on the one shared datapath, step by step:
//   set date loads, checks and emits; add years adds and corrects the day; add months
//   divides by 12 by reciprocal in one step; add days walks one month boundary at a time.
// Reset gives 2001-01-01 and an empty result register; no clearing pass is needed.
// The next request is taken while a result waits; the emit step holds under res_stall.
module calendar_date_adder (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  cda_pkg::req_t   req_data,
    output logic            res_valid,
    input  logic            res_stall,
    output cda_pkg::res_t   res_data
);
    import cda_pkg::*;

    pc_t     pc;
    uword_t  uword;
    status_t status;
    logic    run;

    cda_ucode_rom u_rom (
        .pc    (pc),
        .uword (uword)
    );

    cda_sequencer u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .uword     (uword),
        .status    (status),
        .req_valid (req_valid),
        .action    (req_data.action),
        .pc        (pc),
        .run       (run)
    );

    cda_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .uword     (uword),
        .run       (run),
        .req       (req_data),
        .res_stall (res_stall),
        .res_valid (res_valid),
        .res       (res_data),
        .status    (status)
    );

    assign req_stall = (uword.op != OP_LOAD);

endmodule
